// ----- src/mrt_pkg.sv -----
// Package for the mapped region table: types, codes, state and command encodings.
package mrt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam int PERM_WRITE_BIT = 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [2:0]  permissions;
    logic [31:0] file_offset;
    logic        is_shared;
    logic        has_file;
    logic        is_write_fault;
  } mrt_req_t;

  typedef struct packed {
    logic        ok;
    logic        hit;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [2:0]  region_permissions;
    logic [31:0] region_offset;
    logic        region_shared;
    logic        region_file;
    logic        access_allowed;
  } mrt_res_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [2:0]  perms;
    logic [31:0] offset;
    logic        shared;
    logic        file;
  } mrt_entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTART,
    OP_CLEAR,
    OP_READ_I,
    OP_READ_J,
    OP_FREE,
    OP_INC,
    OP_LOOK,
    OP_COUNT,
    OP_MOD,
    OP_DEC,
    OP_PICK,
    OP_MOVE,
    OP_ADD_INS,
    OP_ADD_SPLIT
  } mrt_op_t;

  typedef struct packed {
    mrt_op_t op;
    logic    fail;
    logic    emit;
  } mrt_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic jdx_end;
    logic free_found;
    logic found;
    logic rm_fail;
    logic drop;
  } mrt_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_FREE,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_INC,
    ST_INS_ADD,
    ST_LK_RD,
    ST_LK,
    ST_CNT_RD,
    ST_CNT,
    ST_CHK,
    ST_MOD_RD,
    ST_MOD,
    ST_DEC_RD,
    ST_DEC,
    ST_PICK_CLR,
    ST_PICK_RD,
    ST_PICK,
    ST_SPLIT,
    ST_SP_RD,
    ST_SP_INC,
    ST_SP_ADD,
    ST_FIN
  } mrt_state_t;

endpackage

// ----- src/mrt_if.sv -----
// Valid/ready channel interfaces for request and result transactions.
interface mrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] start_addr;
  logic [31:0] end_addr;
  logic [2:0]  permissions;
  logic [31:0] file_offset;
  logic        is_shared;
  logic        has_file;
  logic        is_write_fault;

  modport source (output valid, kind, start_addr, end_addr, permissions, file_offset,
                  is_shared, has_file, is_write_fault, input ready);
  modport sink (input valid, kind, start_addr, end_addr, permissions, file_offset,
                is_shared, has_file, is_write_fault, output ready);
endinterface

interface mrt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        hit;
  logic [31:0] region_start;
  logic [31:0] region_end;
  logic [2:0]  region_permissions;
  logic [31:0] region_offset;
  logic        region_shared;
  logic        region_file;
  logic        access_allowed;

  modport source (output valid, ok, hit, region_start, region_end, region_permissions,
                  region_offset, region_shared, region_file, access_allowed, input ready);
  modport sink (input valid, ok, hit, region_start, region_end, region_permissions,
                region_offset, region_shared, region_file, access_allowed, output ready);
endinterface

// ----- src/mapped_region_table_unit.sv -----
// Top level of the mapped region table: controller, datapath and channel hookup.
// The table holds up to ENTRIES regions in a single-port memory that is swept one entry
// at a time (read, then update), with an age per entry ranking regions by recency.
// Every transaction yields exactly one result. A lookup is a single sweep; an insert is a
// free-slot scan over the valid bits, then an age increment sweep; a remove is a count
// sweep, then a trim sweep and a newest-first pick sweep, plus an age close-up sweep for
// every region it deletes and, for every region it splits, a further pick sweep and an
// age increment sweep for the new copy. A new request is taken while the previous result
// still waits in the output register; the finished operation then holds until that
// register drains. No clearing pass is needed after reset: valid bits are flip-flops
// cleared at once.
module mapped_region_table_unit import mrt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  mrt_in_if.sink  in_if,
  mrt_out_if.source out_if
);

  mrt_cmd_t    cmd;
  mrt_status_t status;
  mrt_req_t    req;
  mrt_res_t    res;

  // request transaction payload, captured by the datapath on acceptance
  assign req.kind           = in_if.kind;
  assign req.start_addr     = in_if.start_addr;
  assign req.end_addr       = in_if.end_addr;
  assign req.permissions    = in_if.permissions;
  assign req.file_offset    = in_if.file_offset;
  assign req.is_shared      = in_if.is_shared;
  assign req.has_file       = in_if.has_file;
  assign req.is_write_fault = in_if.is_write_fault;

  mrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_kind   (in_if.kind),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mrt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .status  (status),
    .req_in  (req),
    .res_out (res)
  );

  // result transaction payload straight from the output register
  assign out_if.ok                 = res.ok;
  assign out_if.hit                = res.hit;
  assign out_if.region_start       = res.region_start;
  assign out_if.region_end         = res.region_end;
  assign out_if.region_permissions = res.region_permissions;
  assign out_if.region_offset      = res.region_offset;
  assign out_if.region_shared      = res.region_shared;
  assign out_if.region_file        = res.region_file;
  assign out_if.access_allowed     = res.access_allowed;

endmodule

// ----- src/mrt_datapath.sv -----
// Datapath: region memory, valid and split bits, sweep counters and result register.
module mrt_datapath import mrt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mrt_cmd_t    cmd,
  output mrt_status_t status,
  input  mrt_req_t    req_in,
  output mrt_res_t    res_out
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  mrt_entry_t          mem [ENTRIES];
  logic [IW-1:0]       mem_age [ENTRIES];

  logic [ENTRIES-1:0]  valid_r, split_r;
  logic [CW-1:0]       idx_r, jdx_r, n_free_r, n_split_r;
  logic [IW-1:0]       free_idx_r, best_idx_r, best_age_r, drop_age_r, rd_age_r;
  logic                found_r, free_found_r, ok_r;
  mrt_entry_t          rd_r, best_r;
  mrt_req_t            req_r;
  mrt_res_t            res_r;

  logic [IW-1:0]       ia, ja, ra, wa, wage;
  mrt_entry_t          wd;
  logic                we_ent, we_age;
  logic                v_i, ovl, covered, contains, newer;
  logic [31:0]         lo, hi;

  assign ia = idx_r[IW-1:0];
  assign ja = jdx_r[IW-1:0];
  assign ra = (cmd.op == OP_READ_J) ? ja : ia;
  assign v_i = valid_r[ia];

  // overlap and containment of the entry held in rd_r against the request range
  always_comb begin
    lo       = (req_r.start_addr < rd_r.start_addr) ? rd_r.start_addr : req_r.start_addr;
    hi       = (req_r.end_addr < rd_r.end_addr) ? req_r.end_addr : rd_r.end_addr;
    ovl      = lo < hi;
    covered  = (req_r.start_addr <= rd_r.start_addr) && (req_r.end_addr >= rd_r.end_addr);
    contains = (rd_r.start_addr < req_r.start_addr) && (rd_r.end_addr > req_r.end_addr);
    newer    = !found_r || (rd_age_r < best_age_r);
  end

  // memory write selection
  always_comb begin
    we_ent = 1'b0;
    we_age = 1'b0;
    wa     = ia;
    wd     = rd_r;
    wage   = rd_age_r;
    case (cmd.op)
      OP_INC: begin
        if (v_i) begin
          we_age = 1'b1;
          wage   = rd_age_r + 1'b1;
        end
      end
      OP_DEC: begin
        wa = ja;
        if (valid_r[ja] && (rd_age_r > drop_age_r)) begin
          we_age = 1'b1;
          wage   = rd_age_r - 1'b1;
        end
      end
      OP_MOD: begin
        if (v_i && ovl && !covered && !contains) begin
          we_ent = 1'b1;
          if (req_r.start_addr <= rd_r.start_addr) begin
            wd.start_addr = req_r.end_addr;
            if (rd_r.file) wd.offset = rd_r.offset + (req_r.end_addr - rd_r.start_addr);
          end else begin
            wd.end_addr = req_r.start_addr;
          end
        end
      end
      OP_MOVE: begin
        we_ent        = 1'b1;
        wa            = best_idx_r;
        wd            = best_r;
        wd.start_addr = req_r.end_addr;
        if (best_r.file) wd.offset = best_r.offset + (req_r.end_addr - best_r.start_addr);
      end
      OP_ADD_INS: begin
        we_ent    = 1'b1;
        we_age    = 1'b1;
        wa        = free_idx_r;
        wage      = '0;
        wd.start_addr = req_r.start_addr;
        wd.end_addr   = req_r.end_addr;
        wd.perms      = req_r.permissions;
        wd.offset     = req_r.has_file ? req_r.file_offset : 32'd0;
        wd.shared     = req_r.is_shared;
        wd.file       = req_r.has_file;
      end
      OP_ADD_SPLIT: begin
        we_ent        = 1'b1;
        we_age        = 1'b1;
        wa            = free_idx_r;
        wage          = '0;
        wd            = best_r;
        wd.end_addr   = req_r.start_addr;
        wd.offset     = best_r.file ? best_r.offset : 32'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_ent) mem[wa] <= wd;
    if (we_age) mem_age[wa] <= wage;
    if (cmd.op == OP_READ_I || cmd.op == OP_READ_J) begin
      rd_r     <= mem[ra];
      rd_age_r <= mem_age[ra];
    end
  end

  // control state of the sweeps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      split_r      <= '0;
      idx_r        <= '0;
      jdx_r        <= '0;
      n_free_r     <= '0;
      n_split_r    <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      ok_r         <= 1'b0;
      free_idx_r   <= '0;
      best_idx_r   <= '0;
      best_age_r   <= '0;
      drop_age_r   <= '0;
    end else begin
      if (cmd.fail) ok_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          idx_r        <= '0;
          found_r      <= 1'b0;
          free_found_r <= 1'b0;
          n_free_r     <= '0;
          n_split_r    <= '0;
          ok_r         <= (req_in.kind == KIND_LOOKUP) || (req_in.kind == KIND_REMOVE);
        end
        OP_RESTART: idx_r <= '0;
        OP_CLEAR: begin
          idx_r        <= '0;
          found_r      <= 1'b0;
          free_found_r <= 1'b0;
        end
        OP_FREE: begin
          if (!v_i && !free_found_r) begin
            free_idx_r   <= ia;
            free_found_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_INC: idx_r <= idx_r + 1'b1;
        OP_LOOK: begin
          if (v_i && ovl && newer) begin
            found_r    <= 1'b1;
            best_age_r <= rd_age_r;
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_COUNT: begin
          if (!v_i || (ovl && covered)) n_free_r <= n_free_r + 1'b1;
          else if (ovl && contains) n_split_r <= n_split_r + 1'b1;
          idx_r <= idx_r + 1'b1;
        end
        OP_MOD: begin
          if (v_i && ovl) begin
            if (covered) begin
              valid_r[ia] <= 1'b0;
              drop_age_r  <= rd_age_r;
              jdx_r       <= '0;
            end else if (contains) begin
              split_r[ia] <= 1'b1;
            end
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_DEC: jdx_r <= jdx_r + 1'b1;
        OP_PICK: begin
          if (split_r[ia] && newer) begin
            found_r    <= 1'b1;
            best_age_r <= rd_age_r;
            best_idx_r <= ia;
          end
          if (!v_i && !free_found_r) begin
            free_idx_r   <= ia;
            free_found_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_MOVE: begin
          split_r[best_idx_r] <= 1'b0;
          idx_r               <= '0;
        end
        OP_ADD_INS: begin
          valid_r[free_idx_r] <= 1'b1;
          ok_r                <= 1'b1;
        end
        OP_ADD_SPLIT: valid_r[free_idx_r] <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) req_r <= req_in;
    if ((cmd.op == OP_LOOK && v_i && ovl && newer) || (cmd.op == OP_PICK && split_r[ia] && newer))
      best_r <= rd_r;
    if (cmd.emit) begin
      res_r.ok  <= ok_r;
      res_r.hit <= (req_r.kind == KIND_LOOKUP) && found_r;
      if ((req_r.kind == KIND_LOOKUP) && found_r) begin
        res_r.region_start       <= best_r.start_addr;
        res_r.region_end         <= best_r.end_addr;
        res_r.region_permissions <= best_r.perms;
        res_r.region_offset      <= best_r.offset;
        res_r.region_shared      <= best_r.shared;
        res_r.region_file        <= best_r.file;
        res_r.access_allowed     <= (best_r.perms != 3'd0) &&
                                    !(req_r.is_write_fault && !best_r.perms[PERM_WRITE_BIT]);
      end else begin
        res_r.region_start       <= '0;
        res_r.region_end         <= '0;
        res_r.region_permissions <= '0;
        res_r.region_offset      <= '0;
        res_r.region_shared      <= 1'b0;
        res_r.region_file        <= 1'b0;
        res_r.access_allowed     <= 1'b0;
      end
    end
  end

  assign res_out = res_r;

  always_comb begin
    status.idx_end    = idx_r == CW'(ENTRIES);
    status.jdx_end    = jdx_r == CW'(ENTRIES);
    status.free_found = free_found_r;
    status.found      = found_r;
    status.rm_fail    = n_split_r > n_free_r;
    status.drop       = v_i && ovl && covered;
  end

endmodule

// ----- src/mrt_ctrl.sv -----
// Controller: sequences the sweeps of each operation and owns the handshakes.
module mrt_ctrl import mrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  output logic        out_valid,
  input  logic        out_ready,
  input  mrt_status_t status,
  output mrt_cmd_t    cmd
);

  mrt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    cmd.fail      = 1'b0;
    cmd.emit      = 1'b0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          case (in_kind)
            KIND_INSERT: state_nxt = ST_INS_FREE;
            KIND_LOOKUP: state_nxt = ST_LK_RD;
            KIND_REMOVE: state_nxt = ST_CNT_RD;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_INS_FREE: begin
        if (status.idx_end) state_nxt = ST_INS_CHK;
        else cmd.op = OP_FREE;
      end
      ST_INS_CHK: begin
        if (status.free_found) begin
          cmd.op    = OP_RESTART;
          state_nxt = ST_INS_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_INS_RD: begin
        if (status.idx_end) state_nxt = ST_INS_ADD;
        else begin
          cmd.op    = OP_READ_I;
          state_nxt = ST_INS_INC;
        end
      end
      ST_INS_INC: begin
        cmd.op    = OP_INC;
        state_nxt = ST_INS_RD;
      end
      ST_INS_ADD: begin
        cmd.op    = OP_ADD_INS;
        state_nxt = ST_FIN;
      end
      ST_LK_RD: begin
        if (status.idx_end) state_nxt = ST_FIN;
        else begin
          cmd.op    = OP_READ_I;
          state_nxt = ST_LK;
        end
      end
      ST_LK: begin
        cmd.op    = OP_LOOK;
        state_nxt = ST_LK_RD;
      end
      ST_CNT_RD: begin
        if (status.idx_end) state_nxt = ST_CHK;
        else begin
          cmd.op    = OP_READ_I;
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        cmd.op    = OP_COUNT;
        state_nxt = ST_CNT_RD;
      end
      ST_CHK: begin
        if (status.rm_fail) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.op    = OP_RESTART;
          state_nxt = ST_MOD_RD;
        end
      end
      ST_MOD_RD: begin
        if (status.idx_end) state_nxt = ST_PICK_CLR;
        else begin
          cmd.op    = OP_READ_I;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.op    = OP_MOD;
        state_nxt = status.drop ? ST_DEC_RD : ST_MOD_RD;
      end
      ST_DEC_RD: begin
        if (status.jdx_end) state_nxt = ST_MOD_RD;
        else begin
          cmd.op    = OP_READ_J;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.op    = OP_DEC;
        state_nxt = ST_DEC_RD;
      end
      ST_PICK_CLR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = ST_PICK_RD;
      end
      ST_PICK_RD: begin
        if (status.idx_end) state_nxt = ST_SPLIT;
        else begin
          cmd.op    = OP_READ_I;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.op    = OP_PICK;
        state_nxt = ST_PICK_RD;
      end
      ST_SPLIT: begin
        if (status.found) begin
          cmd.op    = OP_MOVE;
          state_nxt = ST_SP_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SP_RD: begin
        if (status.idx_end) state_nxt = ST_SP_ADD;
        else begin
          cmd.op    = OP_READ_I;
          state_nxt = ST_SP_INC;
        end
      end
      ST_SP_INC: begin
        cmd.op    = OP_INC;
        state_nxt = ST_SP_RD;
      end
      ST_SP_ADD: begin
        cmd.op    = OP_ADD_SPLIT;
        state_nxt = ST_PICK_CLR;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/mrt_checker.sv -----
// Port-level checker for the mapped region table, bound to the top level.
module mrt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic        hit,
  input logic [2:0]  region_permissions,
  input logic [31:0] region_start,
  input logic        access_allowed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit |-> ok)
    else $error("hit reported without ok");

  a_allow_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && access_allowed |-> hit && (region_permissions != 3'd0))
    else $error("access allowed without a permitted hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> (region_start == 32'd0) && (region_permissions == 3'd0))
    else $error("region fields set on a miss");

endmodule

bind mapped_region_table_unit mrt_checker u_mrt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .ok                 (out_if.ok),
  .hit                (out_if.hit),
  .region_permissions (out_if.region_permissions),
  .region_start       (out_if.region_start),
  .access_allowed     (out_if.access_allowed)
);

// ----- bench/mrt_tb_checker.sv -----
// Checker for the mapped region table: predicts each result and compares it with the block's.
`timescale 1ns / 100ps

module mrt_tb_checker import mrt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mrt_in_if.sink  in_mon,
  mrt_out_if.sink out_mon,
  output int      fail_count,
  output int      pending
);

  typedef struct {
    logic        ok;
    logic        hit;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [2:0]  rperm;
    logic [31:0] roff;
    logic        rshared;
    logic        rfile;
    logic        allowed;
  } region_res_t;

  // shadow table
  bit          tv    [ENTRIES];
  logic [31:0] tstart[ENTRIES];
  logic [31:0] tend  [ENTRIES];
  logic [2:0]  tperm [ENTRIES];
  logic [31:0] toff  [ENTRIES];
  logic        tsh   [ENTRIES];
  logic        tfile [ENTRIES];
  int          tage  [ENTRIES];

  region_res_t awaited_results[$];

  function automatic bit hits(int i, logic [31:0] s, logic [31:0] e);
    logic [31:0] lo, hi;
    lo = (s < tstart[i]) ? tstart[i] : s;
    hi = (e < tend[i]) ? e : tend[i];
    return lo < hi;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < ENTRIES; i++) if (!tv[i]) return i;
    return -1;
  endfunction

  function automatic void add_region(int k, logic [31:0] s, logic [31:0] e, logic [2:0] p,
                                     logic [31:0] o, logic sh, logic f);
    for (int i = 0; i < ENTRIES; i++) if (tv[i]) tage[i]++;
    tv[k] = 1; tstart[k] = s; tend[k] = e; tperm[k] = p;
    toff[k] = f ? o : 32'd0; tsh[k] = sh; tfile[k] = f; tage[k] = 0;
  endfunction

  function automatic void trim_start(int i, logic [31:0] ns);
    if (tfile[i]) toff[i] = toff[i] + (ns - tstart[i]);
    tstart[i] = ns;
  endfunction

  function automatic bit take_out(logic [31:0] s, logic [31:0] e);
    bit sp[ENTRIES];
    int nsplit, nfree, a, best, k;
    logic [31:0] os, oo;
    nsplit = 0; nfree = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      sp[i] = 0;
      if (!tv[i]) nfree++;
      else if (hits(i, s, e)) begin
        if (s <= tstart[i] && e >= tend[i]) nfree++;
        else if (tstart[i] < s && tend[i] > e) nsplit++;
      end
    end
    if (nsplit > nfree) return 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tv[i] || !hits(i, s, e)) continue;
      if (s <= tstart[i] && e >= tend[i]) begin
        a = tage[i];
        tv[i] = 0;
        for (int j = 0; j < ENTRIES; j++) if (tv[j] && tage[j] > a) tage[j]--;
      end else if (tstart[i] < s && tend[i] > e) sp[i] = 1;
      else if (s <= tstart[i]) trim_start(i, e);
      else tend[i] = s;
    end
    forever begin
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (sp[i] && (best < 0 || tage[i] < tage[best])) best = i;
      if (best < 0) break;
      sp[best] = 0;
      k = lowest_free();
      if (k < 0) break;
      os = tstart[best]; oo = toff[best];
      trim_start(best, e);
      add_region(k, os, s, tperm[best], oo, tsh[best], tfile[best]);
    end
    return 1;
  endfunction

  function automatic region_res_t predict_region_op(logic [1:0] kind, logic [31:0] s,
      logic [31:0] e, logic [2:0] p, logic [31:0] o, logic sh, logic f, logic wr);
    region_res_t r;
    int k, best;
    r = '{default: '0};
    if (kind == KIND_INSERT) begin
      k = lowest_free();
      if (k >= 0) begin
        add_region(k, s, e, p, o, sh, f);
        r.ok = 1;
      end
    end else if (kind == KIND_LOOKUP) begin
      r.ok = 1;
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (tv[i] && hits(i, s, e) && (best < 0 || tage[i] < tage[best])) best = i;
      if (best >= 0) begin
        r.hit = 1; r.rstart = tstart[best]; r.rend = tend[best]; r.rperm = tperm[best];
        r.roff = toff[best]; r.rshared = tsh[best]; r.rfile = tfile[best];
        r.allowed = (tperm[best] != 0) && !(wr && !tperm[best][PERM_WRITE_BIT]);
      end
    end else if (kind == KIND_REMOVE) begin
      r.ok = take_out(s, e);
    end
    return r;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    region_res_t w;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) tv[i] = 0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(predict_region_op(in_mon.kind, in_mon.start_addr,
          in_mon.end_addr, in_mon.permissions, in_mon.file_offset, in_mon.is_shared,
          in_mon.has_file, in_mon.is_write_fault));
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          w = awaited_results.pop_front();
          if (out_mon.ok !== w.ok) begin
            $error("ok: expected %0h got %0h", w.ok, out_mon.ok); fail_count++;
          end
          if (out_mon.hit !== w.hit) begin
            $error("hit: expected %0h got %0h", w.hit, out_mon.hit); fail_count++;
          end
          if (out_mon.region_start !== w.rstart) begin
            $error("region_start: expected %0h got %0h", w.rstart, out_mon.region_start);
            fail_count++;
          end
          if (out_mon.region_end !== w.rend) begin
            $error("region_end: expected %0h got %0h", w.rend, out_mon.region_end);
            fail_count++;
          end
          if (out_mon.region_permissions !== w.rperm) begin
            $error("region_permissions: expected %0h got %0h", w.rperm,
                   out_mon.region_permissions);
            fail_count++;
          end
          if (out_mon.region_offset !== w.roff) begin
            $error("region_offset: expected %0h got %0h", w.roff, out_mon.region_offset);
            fail_count++;
          end
          if (out_mon.region_shared !== w.rshared) begin
            $error("region_shared: expected %0h got %0h", w.rshared, out_mon.region_shared);
            fail_count++;
          end
          if (out_mon.region_file !== w.rfile) begin
            $error("region_file: expected %0h got %0h", w.rfile, out_mon.region_file);
            fail_count++;
          end
          if (out_mon.access_allowed !== w.allowed) begin
            $error("access_allowed: expected %0h got %0h", w.allowed,
                   out_mon.access_allowed);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the mapped region table: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb;
  import mrt_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  bit   stim_done = 0;

  mrt_in_if  req_ch();
  mrt_out_if res_ch();

  mapped_region_table_unit uut (.clk(clk), .rst_n(rst_n), .in_if(req_ch), .out_if(res_ch));

  mrt_tb_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(req_ch), .out_mon(res_ch),
                      .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog: once idle_cycles passes its limit with no handshake on either channel, the
  // block is taken to have hung and the run ends with an error.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 50000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stalls on its own pattern: a random mode per window, including
  // windows that never stall.
  int stall_mode = 0;
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2: res_ch.ready <= ($urandom_range(0, 3) == 0);
      default: res_ch.ready <= rx_cycle[3];
    endcase
  end

  // Send one transaction: drive at the falling edge, hold until accepted.
  task automatic send_region_op(logic [1:0] kind, logic [31:0] s, logic [31:0] e,
                                logic [2:0] p = 3'd0, logic [31:0] o = 32'd0,
                                logic sh = 0, logic f = 0, logic wr = 0);
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind; req_ch.start_addr <= s; req_ch.end_addr <= e;
    req_ch.permissions <= p; req_ch.file_offset <= o; req_ch.is_shared <= sh;
    req_ch.has_file <= f; req_ch.is_write_fault <= wr;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    req_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 30)) @(negedge clk);
  endtask

  // Addresses drawn from a small window so regions collide often; some from anywhere.
  function automatic logic [31:0] pick_addr(logic [31:0] base);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return base + $urandom_range(0, 15) * 32'h100;
  endfunction

  initial begin
    logic [31:0] base, s, e;
    int burst;
    req_ch.valid = 0; req_ch.kind = KIND_INSERT; req_ch.start_addr = 0;
    req_ch.end_addr = 0; req_ch.permissions = 0; req_ch.file_offset = 0;
    req_ch.is_shared = 0; req_ch.has_file = 0; req_ch.is_write_fault = 0;
    res_ch.ready = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // Directed: lookup on empty, inserts with extremes, split, trims, bad kinds.
    send_region_op(KIND_LOOKUP, 32'h0, 32'hFFFFFFFF);
    send_region_op(KIND_INSERT, 32'h1000, 32'h5000, 3'd7, 32'hFFFFF000, 1, 1);
    send_region_op(KIND_INSERT, 32'h8000, 32'h9000, 3'd1, 32'h1234, 0, 0); // offset dropped
    send_region_op(KIND_INSERT, 32'h7000, 32'h7000, 3'd2, 32'h0, 1, 0);    // empty region
    send_region_op(KIND_INSERT, 32'hFFFFFFFF, 32'h0, 3'd0, 32'h5, 0, 1);   // inverted
    send_region_op(KIND_LOOKUP, 32'h1800, 32'h1801, 3'd0, 0, 0, 0, 1);
    send_region_op(KIND_LOOKUP, 32'h8000, 32'h8001, 3'd0, 0, 0, 0, 1);     // write denied
    send_region_op(KIND_LOOKUP, 32'h7000, 32'h7001);
    send_region_op(KIND_LOOKUP, 32'h2000, 32'h2000);                       // empty range
    send_region_op(KIND_REMOVE, 32'h2000, 32'h2000);
    send_region_op(KIND_REMOVE, 32'h2000, 32'h3000);                       // split
    send_region_op(KIND_LOOKUP, 32'h1000, 32'h5000);
    send_region_op(KIND_LOOKUP, 32'h3000, 32'h3001);
    send_region_op(KIND_REMOVE, 32'h0, 32'h1800);                          // start trim
    send_region_op(KIND_REMOVE, 32'h4800, 32'h8800);                       // end/start trims
    send_region_op(KIND_LOOKUP, 32'h0, 32'hFFFFFFFF);
    send_region_op(KIND_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd4, 32'hFFFFFFFF, 1, 1);
    send_region_op(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 32'hFFFFFFFF, 1, 1, 1);
    // Fill the table, then overflow it and force a split with no room.
    for (int i = 0; i < 17; i++)
      send_region_op(KIND_INSERT, 32'h10000, 32'h20000, i[2:0], i, i[0], 1);
    send_region_op(KIND_REMOVE, 32'h14000, 32'h15000);
    send_region_op(KIND_REMOVE, 32'h0, 32'hFFFFFFFF);

    // Random: bursts with gaps; mostly inserts and removes on a shared window.
    base = 32'h40000;
    for (int n = 0; n < 400; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        s = pick_addr(base);
        e = ($urandom_range(0, 7) == 0) ? pick_addr(base) : s + $urandom_range(1, 8) * 32'h100;
        case ($urandom_range(0, 19))
          0: send_region_op(2'd3, $urandom(), $urandom(), 3'($urandom()), $urandom(),
                            1'($urandom()), 1'($urandom()), 1'($urandom()));
          1, 2, 3, 4, 5, 6: send_region_op(KIND_INSERT, s, e, 3'($urandom()), $urandom(),
                                           1'($urandom()), 1'($urandom()));
          7, 8, 9, 10, 11, 12: send_region_op(KIND_LOOKUP, s,
                                 $urandom_range(0, 1) ? s + 1 : e, 3'd0, 0, 0, 0,
                                 1'($urandom()));
          default: send_region_op(KIND_REMOVE, s, e);
        endcase
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
